// ===== rtl/core/itsg_pkg.sv =====
// shared types, constants and the quarter-wave cosine table for the sample gate
// no dependencies; every other source file but itsg_ram refers to this package by scoped names
`timescale 1ns / 1ps

package itsg_pkg;

	localparam int COS_TABLE_DEPTH  = 1024;
	localparam int SAMPLE_BITS      = 24;
	localparam int WEIGHT_FRAC_BITS = 16;

	localparam int WEIGHT_BITS    = WEIGHT_FRAC_BITS + 1;
	localparam int LUT_ENTRIES    = COS_TABLE_DEPTH + 1;
	localparam int LUT_ADDR_BITS  = $clog2(LUT_ENTRIES);
	localparam int DIST_BITS      = 25;
	localparam int PHASE_BITS     = 2 * DIST_BITS;
	localparam int PHASE_SHIFT    = 8;
	localparam int TURN_BITS      = 17;
	localparam int QUARTER_BITS   = 15;
	localparam int HALF_TURN      = 65536;
	localparam int QUARTER_TURN   = 32768;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WEIGHT_BITS-1:0] W_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	typedef enum logic [2:0] {
		REG_ENABLE,
		REG_GATE_START,
		REG_GATE_WIDTH,
		REG_TAPER_HALF,
		REG_PHASE_STEP
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_PASS,
		CLS_FLAT,
		CLS_TAPER
	} cls_t;

	typedef struct packed {
		logic               enable;
		logic signed [31:0] gate_start;
		logic [24:0]        gate_width;
		logic [23:0]        taper_half;
		logic [24:0]        phase_step;
	} cfg_t;

	typedef struct packed {
		cls_t                   cls;
		logic [DIST_BITS-1:0]   edge_dist;
		logic [SAMPLE_BITS-1:0] smp;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic afull;
	} q_stat_t;

	typedef logic [WEIGHT_BITS-1:0] cos_lut_t [LUT_ENTRIES];

	// cos(pi/2 * k / depth) by a q30 series, rounded to the weight format
	function automatic logic [WEIGHT_BITS-1:0] cos_entry(input int unsigned k);
		logic [63:0] kk;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] r;
		logic [63:0] c;
		kk = 64'(k);
		x  = (PI_HALF_Q30 * kk + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
		x2 = (x * x + (64'd1 << 29)) >> 30;
		t  = Q30_ONE - x2 / 64'd132;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd90;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
		r  = ((x2 * t) >> 30) / 64'd2;
		c  = (r > Q30_ONE) ? 64'd0 : Q30_ONE - r;
		c  = (c + (64'd1 << (29 - WEIGHT_FRAC_BITS))) >> (30 - WEIGHT_FRAC_BITS);
		return c[WEIGHT_BITS-1:0];
	endfunction

	function automatic cos_lut_t build_cos_lut();
		cos_lut_t lut;
		for (int k = 0; k < LUT_ENTRIES; k++) begin
			lut[k] = cos_entry(k);
		end
		return lut;
	endfunction

	localparam cos_lut_t COS_LUT = build_cos_lut();

endpackage

// ===== rtl/core/itsg_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module itsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/itsg_queue.sv =====
// short queue of classified beats between the front and back parts
// depends on itsg_pkg
`timescale 1ns / 1ps

module itsg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  itsg_pkg::q_entry_t wr_entry,
	input  logic               pop,
	output itsg_pkg::q_entry_t head,
	output itsg_pkg::q_stat_t  stat
);

	itsg_pkg::q_entry_t slot_q [itsg_pkg::QUEUE_DEPTH];
	logic [itsg_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [itsg_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [itsg_pkg::QUEUE_CNT_BITS-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == itsg_pkg::QUEUE_PTR_BITS'(itsg_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == itsg_pkg::QUEUE_PTR_BITS'(itsg_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head       = slot_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.afull = (count_q >= itsg_pkg::QUEUE_CNT_BITS'(itsg_pkg::QUEUE_DEPTH - 1));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q != itsg_pkg::QUEUE_CNT_BITS'(itsg_pkg::QUEUE_DEPTH)))
		else $error("queue written while full");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + itsg_pkg::QUEUE_CNT_BITS'(1)))
		else $error("queue fill count lost a beat");

endmodule

// ===== rtl/core/itsg_front.sv =====
// front part: takes a sample, locates it against the window and classifies it
// depends on itsg_pkg
`timescale 1ns / 1ps

module itsg_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [31:0]                          sample_index,
	input  logic signed [itsg_pkg::SAMPLE_BITS-1:0] sample_value,
	input  itsg_pkg::cfg_t                       cfg,
	output logic                                 push,
	output itsg_pkg::q_entry_t                   entry
);

	logic                               vld_s1;
	logic signed [33:0]                 t_s1;
	logic [itsg_pkg::SAMPLE_BITS-1:0]   smp_s1;

	logic signed [33:0] win_w;
	logic signed [33:0] win_h;
	logic signed [33:0] fall_start;
	logic signed [33:0] fall_dist;
	logic               in_win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_s1   <= $signed({2'b00, sample_index} -
				{{2{cfg.gate_start[31]}}, cfg.gate_start});
			smp_s1 <= sample_value;
		end
	end

	assign win_w      = $signed({9'd0, cfg.gate_width});
	assign win_h      = $signed({10'd0, cfg.taper_half});
	assign fall_start = win_w - win_h;
	assign fall_dist  = win_w - t_s1;
	assign in_win     = cfg.enable && !t_s1[33] && (t_s1 <= win_w);

	// falling taper takes precedence where the tapers overlap
	always_comb begin
		entry.smp       = smp_s1;
		entry.edge_dist = t_s1[itsg_pkg::DIST_BITS-1:0];
		entry.cls       = itsg_pkg::CLS_PASS;
		priority if (!in_win) begin
			entry.cls = itsg_pkg::CLS_PASS;
		end else if (t_s1 >= fall_start) begin
			entry.cls       = itsg_pkg::CLS_TAPER;
			entry.edge_dist = fall_dist[itsg_pkg::DIST_BITS-1:0];
		end else if (t_s1 < win_h) begin
			entry.cls = itsg_pkg::CLS_TAPER;
		end else begin
			entry.cls = itsg_pkg::CLS_FLAT;
		end
	end

	assign push = vld_s1;

endmodule

// ===== rtl/core/itsg_back.sv =====
// back part: loads the cosine table after reset, then computes weight and product
// depends on itsg_pkg and itsg_ram
`timescale 1ns / 1ps

module itsg_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  itsg_pkg::cfg_t                         cfg,
	input  itsg_pkg::q_entry_t                     head,
	input  itsg_pkg::q_stat_t                      stat,
	output logic                                   pop,
	output logic                                   fill_busy,
	output logic                                   done,
	output logic signed [itsg_pkg::SAMPLE_BITS-1:0] gated_sample,
	output logic [itsg_pkg::WEIGHT_BITS-1:0]       weight_used
);

	localparam int SB = itsg_pkg::SAMPLE_BITS;
	localparam int WB = itsg_pkg::WEIGHT_BITS;
	localparam int FB = itsg_pkg::WEIGHT_FRAC_BITS;
	localparam int PW = SB + WB;
	localparam int AB = itsg_pkg::LUT_ADDR_BITS;
	localparam int TB = itsg_pkg::TURN_BITS;
	localparam int QW = itsg_pkg::PHASE_BITS - itsg_pkg::PHASE_SHIFT;

	logic          fill_q;
	logic [AB-1:0] fill_idx_q;

	logic                                vld_s3;
	itsg_pkg::cls_t                      cls_s3;
	logic [SB-1:0]                       smp_s3;
	logic [itsg_pkg::PHASE_BITS-1:0]     phase_s3;

	logic           vld_s4;
	itsg_pkg::cls_t cls_s4;
	logic [SB-1:0]  smp_s4;
	logic           neg_s4;

	logic          vld_s5;
	logic [WB-1:0] w_s5;
	logic [SB-1:0] mag_s5;
	logic          sgn_s5;

	logic          vld_s6;
	logic [PW-1:0] prod_s6;
	logic [WB-1:0] w_s6;
	logic          sgn_s6;

	logic                 done_q;
	logic [SB-1:0]        gated_q;
	logic [WB-1:0]        weight_q;

	logic [QW-1:0] q_full;
	logic [TB-1:0] q_sat;
	logic          neg_c4;
	logic [TB-1:0] qf_c4;
	logic [31:0]   kx_c4;
	logic [AB-1:0] k_c4;

	logic [WB-1:0] tab;
	logic [WB:0]   y_sum;
	logic [WB-1:0] y_half;
	logic [WB-1:0] y_clamp;
	logic [WB-1:0] w_taper;
	logic [WB-1:0] w_c5;
	logic [SB-1:0] mag_c5;

	logic [PW-1:0] rnd_sum;
	logic [SB:0]   rnd;
	logic [SB:0]   res;

	itsg_ram #(
		.WIDTH(WB),
		.DEPTH(itsg_pkg::LUT_ENTRIES)
	) u_lut (
		.clk   (clk),
		.we    (fill_q),
		.waddr (fill_idx_q),
		.wdata (itsg_pkg::COS_LUT[fill_idx_q]),
		.raddr (k_c4),
		.rdata (tab)
	);

	assign pop = !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= 1'b1;
			fill_idx_q <= '0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			vld_s6     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (fill_q) begin
				if (fill_idx_q == AB'(itsg_pkg::COS_TABLE_DEPTH)) begin
					fill_q <= 1'b0;
				end else begin
					fill_idx_q <= fill_idx_q + 1'b1;
				end
			end
			vld_s3 <= pop;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			done_q <= vld_s6;
		end
	end

	// phase per sample
	always_ff @(posedge clk) begin
		if (pop) begin
			cls_s3   <= head.cls;
			smp_s3   <= head.smp;
			phase_s3 <= {{(itsg_pkg::PHASE_BITS - itsg_pkg::DIST_BITS){1'b0}}, head.edge_dist} *
				{{(itsg_pkg::PHASE_BITS - 25){1'b0}}, cfg.phase_step};
		end
	end

	// saturate at a half turn, fold onto the quarter wave, table address
	always_comb begin
		q_full = phase_s3[itsg_pkg::PHASE_BITS-1:itsg_pkg::PHASE_SHIFT];
		q_sat  = (q_full > QW'(itsg_pkg::HALF_TURN)) ? TB'(itsg_pkg::HALF_TURN)
			: q_full[TB-1:0];
		neg_c4 = (q_sat > TB'(itsg_pkg::QUARTER_TURN));
		qf_c4  = neg_c4 ? TB'(itsg_pkg::HALF_TURN) - q_sat : q_sat;
		kx_c4  = 32'(qf_c4) * 32'(itsg_pkg::COS_TABLE_DEPTH) +
			32'(itsg_pkg::QUARTER_TURN / 2);
		k_c4   = kx_c4[itsg_pkg::QUARTER_BITS +: AB];
	end

	always_ff @(posedge clk) begin
		cls_s4 <= cls_s3;
		smp_s4 <= smp_s3;
		neg_s4 <= neg_c4;
	end

	// weight is one minus the taper value in a taper, one for a passed sample and zero in the flat part
	always_comb begin
		if (neg_s4) begin
			y_sum = {1'b0, itsg_pkg::W_ONE} + {1'b0, tab} + (WB + 1)'(1);
		end else begin
			y_sum = {1'b0, itsg_pkg::W_ONE} - {1'b0, tab} + (WB + 1)'(1);
		end
		y_half  = y_sum[WB:1];
		y_clamp = (y_half > itsg_pkg::W_ONE) ? itsg_pkg::W_ONE : y_half;
		w_taper = itsg_pkg::W_ONE - y_clamp;
		unique case (cls_s4)
			itsg_pkg::CLS_PASS:  w_c5 = itsg_pkg::W_ONE;
			itsg_pkg::CLS_FLAT:  w_c5 = '0;
			itsg_pkg::CLS_TAPER: w_c5 = w_taper;
			default:             w_c5 = itsg_pkg::W_ONE;
		endcase
		mag_c5 = smp_s4[SB-1] ? (~smp_s4 + 1'b1) : smp_s4;
	end

	always_ff @(posedge clk) begin
		w_s5    <= w_c5;
		mag_s5  <= mag_c5;
		sgn_s5  <= smp_s4[SB-1];
		prod_s6 <= PW'(mag_s5) * PW'(w_s5);
		w_s6    <= w_s5;
		sgn_s6  <= sgn_s5;
	end

	// round half away from zero on the magnitude, then restore the sign
	always_comb begin
		rnd_sum = prod_s6 + (PW'(1) << (FB - 1));
		rnd     = rnd_sum[FB +: SB + 1];
		res     = sgn_s6 ? (~rnd + 1'b1) : rnd;
	end

	always_ff @(posedge clk) begin
		gated_q  <= res[SB-1:0];
		weight_q <= w_s6;
	end

	assign fill_busy    = fill_q;
	assign done         = done_q;
	assign gated_sample = $signed(gated_q);
	assign weight_used  = weight_q;

	a_no_beat_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q |-> !vld_s3)
		else $error("beat entered the back part while the table was loading");

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && cls_s4 == itsg_pkg::CLS_FLAT) |=> (w_s5 == '0))
		else $error("flat part did not give weight zero");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (weight_q <= itsg_pkg::W_ONE))
		else $error("weight above one");

endmodule

// ===== rtl/core/inverse_tukey_sample_gate.sv =====
// top level of the inverse tukey sample gate: register port, front, queue and back
// depends on itsg_pkg, itsg_front, itsg_queue, itsg_back
`timescale 1ns / 1ps

// After reset the block loads its 1025-entry quarter-wave cosine table, one entry per
// cycle, and busy stays high until the table is loaded. From then on a sample is taken
// in every cycle in which start is high and busy is low, one per cycle sustained. Its
// result is shown on gated_sample and weight_used with done high for one cycle, after
// the classify stage, the queue, the phase multiplier, the registered table read, the
// weight register, the output multiplier and the output register. done cannot be held
// off by the receiver. Registers must be written only while idle; the block does not enforce this.
module inverse_tukey_sample_gate (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [31:0]                            sample_index,
	input  logic signed [itsg_pkg::SAMPLE_BITS-1:0] sample_value,
	output logic                                   done,
	output logic signed [itsg_pkg::SAMPLE_BITS-1:0] gated_sample,
	output logic [itsg_pkg::WEIGHT_BITS-1:0]       weight_used,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [4:0]                             paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	itsg_pkg::cfg_t     cfg_q;
	itsg_pkg::reg_idx_t reg_idx;
	logic               cfg_we;

	itsg_pkg::q_entry_t fe_entry;
	itsg_pkg::q_entry_t q_head;
	itsg_pkg::q_stat_t  q_stat;
	logic               fe_push;
	logic               be_pop;
	logic               fill_busy;
	logic               accept;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign reg_idx = itsg_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable     <= 1'b0;
			cfg_q.gate_start <= '0;
			cfg_q.gate_width <= 25'd1;
			cfg_q.taper_half <= 24'd1;
			cfg_q.phase_step <= 25'd16777216;
		end else if (cfg_we) begin
			unique case (reg_idx)
				itsg_pkg::REG_ENABLE:     cfg_q.enable     <= pwdata[0];
				itsg_pkg::REG_GATE_START: cfg_q.gate_start <= $signed(pwdata);
				itsg_pkg::REG_GATE_WIDTH: cfg_q.gate_width <= pwdata[24:0];
				itsg_pkg::REG_TAPER_HALF: cfg_q.taper_half <= pwdata[23:0];
				itsg_pkg::REG_PHASE_STEP: cfg_q.phase_step <= pwdata[24:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			itsg_pkg::REG_ENABLE:     prdata = {31'd0, cfg_q.enable};
			itsg_pkg::REG_GATE_START: prdata = cfg_q.gate_start;
			itsg_pkg::REG_GATE_WIDTH: prdata = {7'd0, cfg_q.gate_width};
			itsg_pkg::REG_TAPER_HALF: prdata = {8'd0, cfg_q.taper_half};
			itsg_pkg::REG_PHASE_STEP: prdata = {7'd0, cfg_q.phase_step};
			default:                  prdata = '0;
		endcase
	end

	// hold off new beats while the table loads or the queue is nearly full
	assign busy   = fill_busy || q_stat.afull;
	assign accept = start && !busy;

	itsg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sample_index (sample_index),
		.sample_value (sample_value),
		.cfg          (cfg_q),
		.push         (fe_push),
		.entry        (fe_entry)
	);

	itsg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fe_push),
		.wr_entry (fe_entry),
		.pop      (be_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	itsg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (q_head),
		.stat         (q_stat),
		.pop          (be_pop),
		.fill_busy    (fill_busy),
		.done         (done),
		.gated_sample (gated_sample),
		.weight_used  (weight_used)
	);

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for inverse_tukey_sample_gate: directed window cases, then random phases
// depends on itsg_pkg and inverse_tukey_sample_gate; predicts each beat in a small scoreboard class
`timescale 1ns / 1ps

class gate_scoreboard;
	typedef struct {
		logic signed [itsg_pkg::SAMPLE_BITS-1:0] gated;
		logic [itsg_pkg::WEIGHT_BITS-1:0]        weight;
	} gate_beat_t;

	logic                             enable;
	logic signed [31:0]               gate_start;
	logic [24:0]                      gate_width;
	logic [23:0]                      taper_half;
	logic [24:0]                      phase_step;
	logic [itsg_pkg::WEIGHT_BITS-1:0] cos_tab [0:itsg_pkg::COS_TABLE_DEPTH];
	gate_beat_t                       pending_out [$];
	int                               errors;
	int                               n_beats;
	int                               n_pass;
	int                               n_flat;
	int                               n_taper;

	function new();
		for (int k = 0; k <= itsg_pkg::COS_TABLE_DEPTH; k++) begin
			cos_tab[k] = quarter_cos(k);
		end
		enable     = 1'b0;
		gate_start = '0;
		gate_width = 25'd1;
		taper_half = 24'd1;
		phase_step = 25'd16777216;
		errors     = 0;
		n_beats    = 0;
		n_pass     = 0;
		n_flat     = 0;
		n_taper    = 0;
	endfunction

	// q30 taylor series of cos(pi/2 * k / depth), rounded to the weight format
	function logic [itsg_pkg::WEIGHT_BITS-1:0] quarter_cos(int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] acc;
		logic [63:0] r;
		logic [63:0] c;
		logic [63:0] one;
		one = 64'd1 << 30;
		x   = (64'd1686629713 * 64'(k) + 64'(itsg_pkg::COS_TABLE_DEPTH / 2))
			/ 64'(itsg_pkg::COS_TABLE_DEPTH);
		x2  = (x * x + (64'd1 << 29)) >> 30;
		acc = one - x2 / 64'd132;
		acc = one - ((x2 * acc) >> 30) / 64'd90;
		acc = one - ((x2 * acc) >> 30) / 64'd56;
		acc = one - ((x2 * acc) >> 30) / 64'd30;
		acc = one - ((x2 * acc) >> 30) / 64'd12;
		r   = ((x2 * acc) >> 30) / 64'd2;
		c   = (r > one) ? 64'd0 : one - r;
		c   = (c + (64'd1 << (29 - itsg_pkg::WEIGHT_FRAC_BITS))) >> (30 - itsg_pkg::WEIGHT_FRAC_BITS);
		return c[itsg_pkg::WEIGHT_BITS-1:0];
	endfunction

	// one minus the taper value at distance d from the window edge
	function logic [itsg_pkg::WEIGHT_BITS-1:0] taper_gain(logic [63:0] d);
		logic [63:0] q;
		logic [63:0] qf;
		logic [63:0] k;
		logic [63:0] tab;
		logic [63:0] y;
		logic [63:0] one;
		logic        neg;
		one = 64'd1 << itsg_pkg::WEIGHT_FRAC_BITS;
		q   = (d * 64'(phase_step)) >> 8;
		if (q > 64'd65536)
			q = 64'd65536;
		neg = (q > 64'd32768);
		qf  = neg ? 64'd65536 - q : q;
		k   = (qf * 64'(itsg_pkg::COS_TABLE_DEPTH) + 64'd16384) >> 15;
		tab = 64'(cos_tab[k]);
		y   = neg ? (one + tab + 64'd1) >> 1 : (one - tab + 64'd1) >> 1;
		if (y > one)
			y = one;
		return itsg_pkg::WEIGHT_BITS'(one - y);
	endfunction

	function void set_reg(itsg_pkg::reg_idx_t r, logic [31:0] v);
		case (r)
			itsg_pkg::REG_ENABLE:     enable     = v[0];
			itsg_pkg::REG_GATE_START: gate_start = v;
			itsg_pkg::REG_GATE_WIDTH: gate_width = v[24:0];
			itsg_pkg::REG_TAPER_HALF: taper_half = v[23:0];
			itsg_pkg::REG_PHASE_STEP: phase_step = v[24:0];
			default: ;
		endcase
	endfunction

	function void note_sample(logic [31:0] idx, logic signed [itsg_pkg::SAMPLE_BITS-1:0] val);
		longint                           t;
		longint                           wd;
		longint                           hf;
		longint                           s;
		longint                           mag;
		longint                           rnd;
		logic [itsg_pkg::WEIGHT_BITS-1:0] w;
		gate_beat_t                       e;
		t  = longint'({32'd0, idx}) - longint'(gate_start);
		wd = longint'({39'd0, gate_width});
		hf = longint'({40'd0, taper_half});
		s  = longint'(val);
		w  = itsg_pkg::W_ONE;
		if (enable && t >= 0 && t <= wd) begin
			if (t >= wd - hf) begin
				w = taper_gain(64'(wd - t));
				n_taper++;
			end else if (t < hf) begin
				w = taper_gain(64'(t));
				n_taper++;
			end else begin
				w = '0;
				n_flat++;
			end
		end else begin
			n_pass++;
		end
		mag      = (s < 0) ? -s : s;
		rnd      = (mag * longint'({47'd0, w}) + 64'sd32768) >>> 16;
		e.gated  = itsg_pkg::SAMPLE_BITS'((s < 0) ? -rnd : rnd);
		e.weight = w;
		pending_out.push_back(e);
		n_beats++;
	endfunction

	function void check_result(logic signed [itsg_pkg::SAMPLE_BITS-1:0] gated,
			logic [itsg_pkg::WEIGHT_BITS-1:0] weight);
		gate_beat_t e;
		if (pending_out.size() == 0) begin
			$error("unexpected beat: gated_sample %0d weight_used %0d", gated, weight);
			errors++;
			return;
		end
		e = pending_out.pop_front();
		if (gated !== e.gated) begin
			$error("gated_sample: expected %0d, got %0d", e.gated, gated);
			errors++;
		end
		if (weight !== e.weight) begin
			$error("weight_used: expected %0d, got %0d", e.weight, weight);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_BEATS   = 1050;
	localparam int CALM_FROM      = 900;

	logic                                    clk          = 1'b0;
	logic                                    arst_n       = 1'b0;
	logic                                    start        = 1'b0;
	logic [31:0]                             sample_index = '0;
	logic signed [itsg_pkg::SAMPLE_BITS-1:0] sample_value = '0;
	logic                                    psel         = 1'b0;
	logic                                    penable      = 1'b0;
	logic                                    pwrite       = 1'b0;
	logic [4:0]                              paddr        = '0;
	logic [31:0]                             pwdata       = '0;
	logic                                    busy;
	logic                                    done;
	logic signed [itsg_pkg::SAMPLE_BITS-1:0] gated_sample;
	logic [itsg_pkg::WEIGHT_BITS-1:0]        weight_used;
	logic [31:0]                             prdata;
	logic                                    pready;

	gate_scoreboard sb;
	int             stall_cycles = 0;
	int             n_settings   = 0;

	inverse_tukey_sample_gate dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample_index (sample_index),
		.sample_value (sample_value),
		.done         (done),
		.gated_sample (gated_sample),
		.weight_used  (weight_used),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(gated_sample, weight_used);
	end

	// no beat, result or register write for too long means the block hangs
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pwrite)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("inverse_tukey_sample_gate: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_sample(logic [31:0] idx, logic signed [itsg_pkg::SAMPLE_BITS-1:0] val);
		start        <= 1'b1;
		sample_index <= idx;
		sample_value <= val;
		do @(posedge clk); while (busy);
		sb.note_sample(idx, val);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (sb.pending_out.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(itsg_pkg::reg_idx_t r, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'({r, 2'b00});
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(r, v);
	endtask

	task automatic set_window(logic en, logic [31:0] gs, logic [31:0] gw,
			logic [31:0] th, logic [31:0] ps);
		drain_results();
		write_reg(itsg_pkg::REG_ENABLE, {31'd0, en});
		write_reg(itsg_pkg::REG_GATE_START, gs);
		write_reg(itsg_pkg::REG_GATE_WIDTH, gw);
		write_reg(itsg_pkg::REG_TAPER_HALF, th);
		write_reg(itsg_pkg::REG_PHASE_STEP, ps);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	task automatic run_directed();
		longint                                  edge_t [12] = '{-1, 0, 1, 2, 3, 4, 10, 16, 17, 19, 20, 21};
		logic signed [itsg_pkg::SAMPLE_BITS-1:0] vals [4] = '{24'sh7FFFFF, -24'sh800000, -24'sd1, 24'sd12345};
		// gate off after reset
		send_sample(32'd0, -24'sh800000);
		send_sample(32'hFFFF_FFFF, 24'sh7FFFFF);
		// ordinary window with both tapers and a flat part
		set_window(1'b1, 32'd100, 32'd20, 32'd4, 32'd4194304);
		foreach (edge_t[i])
			send_sample(32'(64'd100 + edge_t[i]), vals[i % 4]);
		// tapers overlap
		set_window(1'b1, 32'd7, 32'd6, 32'd5, 32'd3355443);
		send_sample(32'd7, 24'sh7FFFFF);
		send_sample(32'd8, -24'sh800000);
		send_sample(32'd13, 24'sd1000);
		// no taper
		set_window(1'b1, 32'd0, 32'd10, 32'd0, 32'd0);
		send_sample(32'd0, 24'sh7FFFFF);
		send_sample(32'd9, -24'sd77);
		send_sample(32'd10, -24'sh800000);
		// zero phase step inside a taper
		set_window(1'b1, 32'd50, 32'd40, 32'd4, 32'd0);
		send_sample(32'd52, 24'sd4095);
		// phase beyond pi saturates
		set_window(1'b1, 32'd50, 32'd40, 32'd4, 32'd16777216);
		send_sample(32'd53, -24'sd4095);
		// register extremes
		set_window(1'b1, 32'h8000_0000, 32'd16777216, 32'd8388608, 32'd2);
		send_sample(32'd0, 24'sh7FFFFF);
		set_window(1'b1, 32'h7FFF_FFFF, 32'd16777216, 32'd8388608, 32'd2);
		send_sample(32'h7FFF_FFFF + 32'd8388608, -24'sh800000);
		send_sample(32'h7FFF_FFFF + 32'd3, 24'sh7FFFFF);
		send_sample(32'hFFFF_FFFF, -24'sd2);
	endtask

	task automatic random_setting();
		int unsigned wd;
		int unsigned hf;
		int unsigned ps;
		int unsigned gs;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			wd = $urandom_range(1, 200);
		else if (pick < 9)
			wd = $urandom_range(200, 5000);
		else
			wd = ($urandom_range(0, 1) == 0) ? 32'd16777216 : $urandom_range(1, 16777216);
		pick = $urandom_range(0, 19);
		if (pick < 13)
			hf = $urandom_range(1, (wd / 2 > 0) ? wd / 2 : 1);
		else if (pick < 17)
			hf = $urandom_range(wd / 2, wd + 2);
		else if (pick < 18)
			hf = 0;
		else
			hf = (pick == 18) ? 32'd8388608 : $urandom_range(1, 8388608);
		if (hf > 8388608)
			hf = 8388608;
		pick = $urandom_range(0, 19);
		if (pick < 16)
			ps = (hf == 0) ? 0 : 32'd16777216 / hf;
		else if (pick < 18)
			ps = $urandom_range(0, 16777216);
		else
			ps = (pick == 18) ? 0 : 32'd16777216;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			gs = $urandom_range(0, 5000);
		else if (pick < 8)
			gs = 32'(-longint'($urandom_range(0, wd)));
		else if (pick < 9)
			gs = 32'h7FFF_FFFF - $urandom_range(0, wd);
		else
			gs = $urandom();
		set_window(($urandom_range(0, 9) != 0), gs, wd, hf, ps);
	endtask

	task automatic run_random();
		int          sent;
		int          phase_len;
		int          idle_pct;
		longint      t;
		longint      wd;
		longint      hf;
		logic [31:0] idx;
		logic [23:0] val;
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			random_setting();
			phase_len = $urandom_range(30, 90);
			case ($urandom_range(0, 2))
				0:       idle_pct = 0;
				1:       idle_pct = 25;
				default: idle_pct = 60;
			endcase
			wd = longint'({39'd0, sb.gate_width});
			hf = longint'({40'd0, sb.taper_half});
			repeat (phase_len) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: t = longint'($urandom_range(0, 32'(hf) + 4)) - 2;
					4, 5, 6, 7: t = wd + 2 - longint'($urandom_range(0, 32'(hf) + 4));
					8:          t = longint'($urandom_range(0, 32'(wd)));
					default:    t = longint'($urandom()) - longint'(sb.gate_start);
				endcase
				idx = 32'(longint'(sb.gate_start) + t);
				case ($urandom_range(0, 15))
					0:       val = 24'h7FFFFF;
					1:       val = 24'h800000;
					default: val = 24'($urandom());
				endcase
				send_sample(idx, val);
				sent++;
				if (sent < CALM_FROM && $urandom_range(1, 100) <= idle_pct) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (busy);
		run_directed();
		run_random();
		drain_results();
		repeat (10) @(posedge clk);
		$display("%0d samples over %0d window settings", sb.n_beats, n_settings);
		$display("%0d in a taper, %0d zeroed, %0d passed", sb.n_taper, sb.n_flat, sb.n_pass);
		if (sb.errors == 0 && sb.pending_out.size() == 0) begin
			$display("inverse_tukey_sample_gate: match");
		end else begin
			$display("inverse_tukey_sample_gate: mismatch");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/itsg_pkg.sv
rtl/core/itsg_ram.sv
rtl/core/itsg_queue.sv
rtl/core/itsg_front.sv
rtl/core/itsg_back.sv
rtl/core/inverse_tukey_sample_gate.sv
tb/tb.sv
